### rtl/cdh_pkg.sv
// Shared types and constants for the category distance histogram.
package cdh_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 24;
    localparam int DIST_W    = 25;
    localparam int BWID_W    = 20;
    localparam int NBIN_W    = 7;
    localparam int CAT_W     = 4;
    localparam int RBIN_W    = 6;
    localparam int OUT_CNT_W = 16;

    // Internal arithmetic widths.
    localparam int SQ_W   = 2 * COORD_W;
    localparam int RAD_W  = 2 * DIST_W;
    localparam int REM_W  = DIST_W + 4;
    localparam int STEP_W = 5;

    // One result bit per step for both the root and the quotient.
    localparam int SQRT_STEPS = DIST_W;
    localparam int DIV_STEPS  = DIST_W;

    // Largest bin number that the result port shows.
    localparam logic [RBIN_W-1:0] BIN_SAT = {RBIN_W{1'b1}};

    // Command opcodes.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd2;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd3;

    // Result of the distance unit, handed to the control sequencer.
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] dist_val;
        logic [DIST_W-1:0] quot;
    } cdh_unit_res_t;

endpackage

### rtl/cdh_dist_unit.sv
// Distance and bin unit: shared multiplier, then root and division on one shared subtractor.
module cdh_dist_unit
    import cdh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] site_x,
    input  logic signed [COORD_W-1:0] site_y,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [BWID_W-1:0]         bin_width,
    output cdh_unit_res_t             res
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_SQX  = 3'd1;
    localparam logic [2:0] U_SQY  = 3'd2;
    localparam logic [2:0] U_SUM  = 3'd3;
    localparam logic [2:0] U_SQRT = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [COORD_W-1:0] dx_reg, dx_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    logic [BWID_W-1:0]  w_reg, w_next;
    logic [SQ_W-1:0]    prod_reg, prod_next;
    logic [SQ_W-1:0]    acc_reg, acc_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]  root_reg, root_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;

    logic [COORD_W:0]   diff_x, diff_y;
    logic [COORD_W-1:0] abs_x, abs_y;
    logic [COORD_W-1:0] mul_op;
    logic [SQ_W-1:0]    mul_a, mul_res;
    logic [REM_W-1:0]   sub_a, sub_b;
    logic [REM_W:0]     sub_res;
    logic               sub_ok;
    logic [DIST_W-1:0]  root_shift;

    // Absolute coordinate differences, taken when the unit starts.
    assign diff_x = {site_x[COORD_W-1], site_x} - {center_x[COORD_W-1], center_x};
    assign diff_y = {site_y[COORD_W-1], site_y} - {center_y[COORD_W-1], center_y};
    assign abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
    assign abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];

    // The one multiplier squares dx, then dy.
    assign mul_op  = (state_reg == U_SQX) ? dx_reg : dy_reg;
    assign mul_a   = SQ_W'(mul_op);
    assign mul_res = mul_a * mul_a;

    // The one subtractor serves the root steps and the division steps.
    always_comb
    begin
        if (state_reg == U_DIV)
        begin
            sub_a = {rem_reg[REM_W-2:0], root_reg[DIST_W-1]};
            sub_b = REM_W'(w_reg);
        end
        else
        begin
            sub_a = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
            sub_b = REM_W'({root_reg, 2'b01});
        end
    end

    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok     = !sub_res[REM_W];
    assign root_shift = {root_reg[DIST_W-2:0], sub_ok};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        w_next     = w_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dist_next  = dist_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    dx_next    = abs_x;
                    dy_next    = abs_y;
                    w_next     = (bin_width == '0) ? BWID_W'(1) : bin_width;
                    state_next = U_SQX;
                end
            end
            U_SQX:
            begin
                prod_next  = mul_res;
                state_next = U_SQY;
            end
            U_SQY:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_res;
                state_next = U_SUM;
            end
            U_SUM:
            begin
                rad_next   = RAD_W'({1'b0, acc_reg} + {1'b0, prod_reg});
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = U_SQRT;
            end
            U_SQRT:
            begin
                rem_next  = sub_ok ? sub_res[REM_W-1:0] : sub_a;
                root_next = root_shift;
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    dist_next  = root_shift;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next  = sub_ok ? sub_res[REM_W-1:0] : sub_a;
                root_next = root_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        w_reg    <= w_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dist_reg <= dist_next;
    end

    assign res.done     = done_reg;
    assign res.dist_val = dist_reg;
    assign res.quot     = root_reg;

endmodule

### rtl/category_distance_histogram_unit.sv
// Top level of the category distance histogram: registers, sequencer and count store.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------------------
//  command   start, busy               opcode, site_x, site_y, site_category, read_bin
//  result    done (one-cycle strobe)   distance, bin_index, bin_count, out_of_range
//  config    psel, penable, pwrite...  paddr, pwdata, prdata (pready always high)
//
// From acceptance to its result, an add word goes through squaring dx and dy and summing,
// 25 root steps and 25 division steps on the distance unit's single subtractor, handing
// the bin over and a read-modify-write of the count store; a flagged add skips the store.
// A read passes a request and a return state; an unused opcode is answered from idle.
// The clearing pass after reset keeps busy high while it clears the store, one entry a
// cycle; a clear word runs the same pass and gives its result word at its end.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module category_distance_histogram_unit
    import cdh_pkg::*;
#(
    parameter int NUM_CATEGORIES = 10,
    parameter int NUM_BINS       = 64,
    parameter int COUNT_WIDTH    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] site_x,
    input  logic signed [COORD_W-1:0] site_y,
    input  logic [CAT_W-1:0]          site_category,
    input  logic [RBIN_W-1:0]         read_bin,
    output logic                      done,
    output logic [DIST_W-1:0]         distance,
    output logic [RBIN_W-1:0]         bin_index,
    output logic [OUT_CNT_W-1:0]      bin_count,
    output logic                      out_of_range,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int DEPTH  = NUM_CATEGORIES * NUM_BINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_RDREQ = 3'd3;
    localparam logic [2:0] ST_RDRET = 3'd4;

    // Configuration registers.
    logic signed [COORD_W-1:0] center_x_reg, center_y_reg;
    logic [BWID_W-1:0]         bin_width_reg;
    logic [NBIN_W-1:0]         bins_in_use_reg;
    logic                      cfg_wr;

    // Sequencer state.
    logic [2:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              is_add_reg, is_add_next;
    logic              rvalid_reg, rvalid_next;
    logic [CAT_W-1:0]  cat_reg, cat_next;
    logic [DIST_W-1:0] dist_hold_reg, dist_hold_next;
    logic [RBIN_W-1:0] bin_hold_reg, bin_hold_next;

    // Result word registers.
    logic                   done_reg, done_next;
    logic [DIST_W-1:0]      distance_reg, distance_next;
    logic [RBIN_W-1:0]      bin_index_reg, bin_index_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   oor_reg, oor_next;
    logic [31:0]            count_ext;

    // Count store.
    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Distance unit interface.
    logic          unit_start;
    cdh_unit_res_t unit_res;

    logic        accept;
    logic [31:0] lim;
    logic        add_cat_ok;
    logic        add_bin_ok;
    logic        rd_ok;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            bin_width_reg   <= BWID_W'(1);
            bins_in_use_reg <= NBIN_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CENTER_X:    center_x_reg    <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[COORD_W-1:0];
                REG_BIN_WIDTH:   bin_width_reg   <= pwdata[BWID_W-1:0];
                REG_BINS_IN_USE: bins_in_use_reg <= pwdata[NBIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Configuration reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_CENTER_X:    prdata = {{(32-COORD_W){1'b0}}, center_x_reg};
            REG_CENTER_Y:    prdata = {{(32-COORD_W){1'b0}}, center_y_reg};
            REG_BIN_WIDTH:   prdata = {{(32-BWID_W){1'b0}}, bin_width_reg};
            REG_BINS_IN_USE: prdata = {{(32-NBIN_W){1'b0}}, bins_in_use_reg};
            default:         prdata = '0;
        endcase
    end

    cdh_dist_unit u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (unit_start),
        .site_x    (site_x),
        .site_y    (site_y),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .bin_width (bin_width_reg),
        .res       (unit_res)
    );

    // Bin limit and store-range checks.
    assign lim = (32'(bins_in_use_reg) < 32'(NUM_BINS)) ? 32'(bins_in_use_reg)
                                                         : 32'(NUM_BINS);
    assign add_cat_ok = 32'(cat_reg) < 32'(NUM_CATEGORIES);
    assign add_bin_ok = 32'(unit_res.quot) < lim;
    assign rd_ok      = (32'(site_category) < 32'(NUM_CATEGORIES))
                     && (32'(read_bin) < 32'(NUM_BINS));

    // Saturating increment of the count just read.
    assign count_inc = (rd_data_reg == CMAX) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        is_add_next    = is_add_reg;
        rvalid_next    = rvalid_reg;
        cat_next       = cat_reg;
        dist_hold_next = dist_hold_reg;
        bin_hold_next  = bin_hold_reg;
        done_next      = 1'b0;
        distance_next  = distance_reg;
        bin_index_next = bin_index_reg;
        count_next     = count_reg;
        oor_next       = oor_reg;
        unit_start     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = count_inc;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_ADD:
                        begin
                            unit_start  = 1'b1;
                            is_add_next = 1'b1;
                            cat_next    = site_category;
                            state_next  = ST_CALC;
                        end
                        OP_READ:
                        begin
                            is_add_next    = 1'b0;
                            rvalid_next    = rd_ok;
                            addr_next      = rd_ok ? ADDR_W'(32'(site_category) * 32'(NUM_BINS)
                                                             + 32'(read_bin)) : '0;
                            dist_hold_next = '0;
                            bin_hold_next  = read_bin;
                            state_next     = ST_RDREQ;
                        end
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            init_next    = 1'b0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next      = 1'b1;
                            distance_next  = '0;
                            bin_index_next = '0;
                            count_next     = '0;
                            oor_next       = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    // The pass after reset gives no result word.
                    if (!init_reg)
                    begin
                        done_next      = 1'b1;
                        distance_next  = '0;
                        bin_index_next = '0;
                        count_next     = '0;
                        oor_next       = 1'b0;
                    end
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                if (unit_res.done)
                begin
                    bin_hold_next  = (unit_res.quot > DIST_W'(BIN_SAT)) ? BIN_SAT
                                                                         : unit_res.quot[RBIN_W-1:0];
                    dist_hold_next = unit_res.dist_val;
                    if (add_cat_ok && add_bin_ok)
                    begin
                        addr_next   = ADDR_W'(32'(cat_reg) * 32'(NUM_BINS)
                                              + 32'(unit_res.quot));
                        rvalid_next = 1'b1;
                        state_next  = ST_RDREQ;
                    end
                    else
                    begin
                        // Bin beyond use or unknown category: flagged, not counted.
                        done_next      = 1'b1;
                        distance_next  = unit_res.dist_val;
                        bin_index_next = (unit_res.quot > DIST_W'(BIN_SAT)) ? BIN_SAT
                                                                             : unit_res.quot[RBIN_W-1:0];
                        count_next     = '0;
                        oor_next       = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_RDREQ:
            begin
                state_next = ST_RDRET;
            end
            ST_RDRET:
            begin
                done_next      = 1'b1;
                distance_next  = dist_hold_reg;
                bin_index_next = bin_hold_reg;
                oor_next       = 1'b0;
                if (is_add_reg)
                begin
                    mem_we     = 1'b1;
                    count_next = count_inc;
                end
                else
                begin
                    count_next = rvalid_reg ? rd_data_reg : '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            init_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        is_add_reg    <= is_add_next;
        rvalid_reg    <= rvalid_next;
        cat_reg       <= cat_next;
        dist_hold_reg <= dist_hold_next;
        bin_hold_reg  <= bin_hold_next;
        distance_reg  <= distance_next;
        bin_index_reg <= bin_index_next;
        count_reg     <= count_next;
        oor_reg       <= oor_next;
    end

    // Count store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Result word ports.
    assign count_ext    = 32'(count_reg);
    assign done         = done_reg;
    assign distance     = distance_reg;
    assign bin_index    = bin_index_reg;
    assign bin_count    = count_ext[OUT_CNT_W-1:0];
    assign out_of_range = oor_reg;

`ifndef SYNTH
    // The distance unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_res.done |-> state_reg == ST_CALC)
        else $error("distance unit finished outside the calculation state");

    // A result word is given only as the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while the block is still busy");

    // A flagged add never reports a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> bin_count == '0)
        else $error("flagged word carries a nonzero count");

    // The clearing sweep stays inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> clr_cnt_reg <= ADDR_W'(DEPTH - 1))
        else $error("clearing sweep ran past the end of the store");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the category distance histogram unit.
module tb_top;
    import cdh_pkg::*;

    localparam int NUM_CAT     = 10;
    localparam int NUM_BIN     = 64;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_WORDS = 300;

    // Kinds of entries in the stimulus queue.
    typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN, ACT_PACE} action_kind_t;

    typedef enum logic [1:0] {DRV_RUN, DRV_WAIT_IDLE, DRV_APB_SETUP, DRV_APB_ACCESS}
        drv_phase_t;

    typedef struct {
        action_kind_t              kind;
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] site_x;
        logic signed [COORD_W-1:0] site_y;
        logic [CAT_W-1:0]          cat;
        logic [RBIN_W-1:0]         rbin;
        logic [1:0]                reg_idx;
        logic [31:0]               reg_data;
        int                        pace;
    } stim_action_t;

    typedef struct {
        logic [DIST_W-1:0]    distance;
        logic [RBIN_W-1:0]    bin_index;
        logic [OUT_CNT_W-1:0] bin_count;
        logic                 out_of_range;
    } bin_result_t;

    // Block ports.
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                opcode = OP_ADD;
    logic signed [COORD_W-1:0] site_x = '0;
    logic signed [COORD_W-1:0] site_y = '0;
    logic [CAT_W-1:0]          site_category = '0;
    logic [RBIN_W-1:0]         read_bin = '0;
    logic                      done;
    logic [DIST_W-1:0]         distance;
    logic [RBIN_W-1:0]         bin_index;
    logic [OUT_CNT_W-1:0]      bin_count;
    logic                      out_of_range;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [3:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;

    // Stimulus and expected result words.
    stim_action_t site_words[$];
    bin_result_t  due_results[$];

    // Predictor copy of the registers and the count store.
    logic signed [COORD_W-1:0] cfg_center_x = '0;
    logic signed [COORD_W-1:0] cfg_center_y = '0;
    logic [BWID_W-1:0]         cfg_bin_width = BWID_W'(1);
    logic [NBIN_W-1:0]         cfg_bins_in_use = NBIN_W'(64);
    logic [OUT_CNT_W-1:0]      hist_counts [NUM_CAT][NUM_BIN];

    // Register values seen by the stimulus generator.
    int gen_center_x = 0;
    int gen_center_y = 0;
    int gen_bin_width = 1;
    int gen_bins_in_use = 64;

    // Driver state.
    drv_phase_t   drv_phase = DRV_RUN;
    stim_action_t held_action;
    int           gap_left = 0;
    int           sender_idle_pct = 18;
    logic         stim_done = 1'b0;

    // Run statistics.
    int words_by_op [4] = '{0, 0, 0, 0};
    int flagged_adds = 0;
    int config_writes = 0;
    int results_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;

    category_distance_histogram_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .site_x        (site_x),
        .site_y        (site_y),
        .site_category (site_category),
        .read_bin      (read_bin),
        .done          (done),
        .distance      (distance),
        .bin_index     (bin_index),
        .bin_count     (bin_count),
        .out_of_range  (out_of_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a 12 unit period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Floor of the square root, found one root bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    // Works out the result word of one accepted command word and updates the store.
    function automatic bin_result_t predict_bin_result(input stim_action_t w);
        bin_result_t     r;
        longint          dx;
        longint          dy;
        longint unsigned root_len;
        longint unsigned quot;
        longint unsigned width;
        longint unsigned lim;
        r.distance     = '0;
        r.bin_index    = '0;
        r.bin_count    = '0;
        r.out_of_range = 1'b0;
        case (w.opcode)
            OP_ADD:
            begin
                dx = longint'(w.site_x) - longint'(cfg_center_x);
                dy = longint'(w.site_y) - longint'(cfg_center_y);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                root_len = floor_root(longint'(dx * dx + dy * dy));
                width    = (cfg_bin_width == 0) ? 1 : cfg_bin_width;
                quot     = root_len / width;
                lim      = (cfg_bins_in_use < NUM_BIN) ? cfg_bins_in_use : NUM_BIN;
                r.distance  = root_len[DIST_W-1:0];
                r.bin_index = (quot > BIN_SAT) ? BIN_SAT : quot[RBIN_W-1:0];
                // Bins past the limit and unknown categories are flagged, not counted.
                if (quot >= lim || w.cat >= NUM_CAT)
                begin
                    r.out_of_range = 1'b1;
                    flagged_adds++;
                end
                else
                begin
                    if (hist_counts[w.cat][quot] != '1)
                        hist_counts[w.cat][quot] = hist_counts[w.cat][quot] + 1'b1;
                    r.bin_count = hist_counts[w.cat][quot];
                end
            end
            OP_READ:
            begin
                r.bin_index = w.rbin;
                if (w.cat < NUM_CAT)
                    r.bin_count = hist_counts[w.cat][w.rbin];
            end
            OP_CLEAR:
            begin
                foreach (hist_counts[c, b])
                    hist_counts[c][b] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, what, got, want);
    endtask

    function automatic int rand24();
        return int'($urandom_range(16777215)) - 8388608;
    endfunction

    function automatic int clamp24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return int'(v);
    endfunction

    task automatic queue_word(input logic [1:0] op, input int x, input int y,
                              input int cat, input int rbin);
        stim_action_t a;
        a.kind   = ACT_WORD;
        a.opcode = op;
        a.site_x = x[COORD_W-1:0];
        a.site_y = y[COORD_W-1:0];
        a.cat    = cat[CAT_W-1:0];
        a.rbin   = rbin[RBIN_W-1:0];
        a.pace   = 0;
        site_words = {site_words, a};
    endtask

    // Register write; bits above the register width carry random junk.
    task automatic queue_config(input logic [1:0] idx, input int value);
        stim_action_t a;
        a.kind     = ACT_CFG;
        a.reg_idx  = idx;
        a.reg_data = $urandom();
        a.pace     = 0;
        case (idx)
            REG_CENTER_X:
            begin
                a.reg_data[COORD_W-1:0] = value[COORD_W-1:0];
                gen_center_x = value;
            end
            REG_CENTER_Y:
            begin
                a.reg_data[COORD_W-1:0] = value[COORD_W-1:0];
                gen_center_y = value;
            end
            REG_BIN_WIDTH:
            begin
                a.reg_data[BWID_W-1:0] = value[BWID_W-1:0];
                gen_bin_width = value;
            end
            default:
            begin
                a.reg_data[NBIN_W-1:0] = value[NBIN_W-1:0];
                gen_bins_in_use = value;
            end
        endcase
        site_words = {site_words, a};
    endtask

    task automatic queue_marker(input action_kind_t kind, input int pace);
        stim_action_t a;
        a.kind = kind;
        a.pace = pace;
        site_words = {site_words, a};
    endtask

    // One random command word, aimed mostly at the bins in use around the center.
    task automatic queue_random_word();
        int     pick;
        int     lim;
        int     cat;
        int     span;
        int     dx;
        int     dy;
        longint reach;
        pick = $urandom_range(999);
        lim  = (gen_bins_in_use == 0) ? 1 : ((gen_bins_in_use > 64) ? 64 : gen_bins_in_use);
        cat  = ($urandom_range(99) < 90) ? $urandom_range(9) : $urandom_range(15, 10);
        if (pick < 15)
            queue_word(OP_CLEAR, rand24(), rand24(), $urandom_range(15), $urandom_range(63));
        else if (pick < 70)
            queue_word(OP_NONE, rand24(), rand24(), $urandom_range(15), $urandom_range(63));
        else if (pick < 300)
            queue_word(OP_READ, rand24(), rand24(), cat,
                       ($urandom_range(99) < 70) ? $urandom_range(lim - 1)
                                                 : $urandom_range(63));
        else
        begin
            reach = longint'(lim) * ((gen_bin_width == 0) ? 1 : gen_bin_width);
            reach = reach + reach / 4 + 2;
            if (reach > 16777215)
                reach = 16777215;
            span = int'(reach);
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                dx = int'($urandom_range(2 * span)) - span;
                dy = int'($urandom_range(2 * span)) - span;
            end
            else
            begin
                dx = int'($urandom_range(6)) - 3;
                dy = int'($urandom_range(6)) - 3;
            end
            if (pick < 85)
                queue_word(OP_ADD, clamp24(longint'(gen_center_x) + dx),
                           clamp24(longint'(gen_center_y) + dy), cat, $urandom_range(63));
            else
                queue_word(OP_ADD, rand24(), rand24(), cat, $urandom_range(63));
        end
    endtask

    // Driver: offers command words, inserts idle gaps and runs register writes.
    always @(posedge clk)
    begin
        stim_action_t act;
        logic         launch;
        launch = 1'b0;
        if (rst_n)
        begin
            // A word offered while busy is low is taken at this edge.
            if (start && !busy)
            begin
                due_results = {due_results, predict_bin_result(held_action)};
                words_by_op[held_action.opcode]++;
            end
            if (start && busy)
                launch = 1'b1;
            else
            begin
                case (drv_phase)
                    DRV_RUN:
                    begin
                        if (gap_left != 0)
                            gap_left--;
                        else if (site_words.size() == 0)
                            stim_done <= 1'b1;
                        else
                        begin
                            act = site_words[0];
                            case (act.kind)
                                ACT_WORD:
                                begin
                                    if ($urandom_range(99) < sender_idle_pct)
                                        gap_left = $urandom_range(64, 1);
                                    else
                                    begin
                                        held_action = site_words.pop_front();
                                        launch = 1'b1;
                                        opcode <= act.opcode;
                                        site_x <= act.site_x;
                                        site_y <= act.site_y;
                                        site_category <= act.cat;
                                        read_bin <= act.rbin;
                                    end
                                end
                                ACT_PACE:
                                begin
                                    act = site_words.pop_front();
                                    sender_idle_pct = act.pace;
                                end
                                default:
                                begin
                                    held_action = site_words.pop_front();
                                    drv_phase = DRV_WAIT_IDLE;
                                end
                            endcase
                        end
                    end
                    // Hold off until every expected word is back and the block is idle.
                    DRV_WAIT_IDLE:
                    begin
                        if (due_results.size() == 0 && !busy && !done)
                        begin
                            if (held_action.kind == ACT_CFG)
                            begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= {held_action.reg_idx, 2'b00};
                                pwdata <= held_action.reg_data;
                                drv_phase = DRV_APB_SETUP;
                            end
                            else
                                drv_phase = DRV_RUN;
                        end
                    end
                    DRV_APB_SETUP:
                    begin
                        penable <= 1'b1;
                        drv_phase = DRV_APB_ACCESS;
                    end
                    default:
                    begin
                        if (pready)
                        begin
                            case (held_action.reg_idx)
                                REG_CENTER_X:
                                    cfg_center_x = held_action.reg_data[COORD_W-1:0];
                                REG_CENTER_Y:
                                    cfg_center_y = held_action.reg_data[COORD_W-1:0];
                                REG_BIN_WIDTH:
                                    cfg_bin_width = held_action.reg_data[BWID_W-1:0];
                                default:
                                    cfg_bins_in_use = held_action.reg_data[NBIN_W-1:0];
                            endcase
                            config_writes++;
                            psel <= 1'b0;
                            penable <= 1'b0;
                            pwrite <= 1'b0;
                            drv_phase = DRV_RUN;
                        end
                    end
                endcase
            end
        end
        start <= launch;
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge clk)
    begin
        bin_result_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
                report_mismatch("result word with none expected, distance", distance, 0);
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                if (distance !== want.distance)
                    report_mismatch("distance", distance, want.distance);
                if (bin_index !== want.bin_index)
                    report_mismatch("bin_index", bin_index, want.bin_index);
                if (bin_count !== want.bin_count)
                    report_mismatch("bin_count", bin_count, want.bin_count);
                if (out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", out_of_range, want.out_of_range);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int p;
        int bw;
        int biu;
        int cx;
        int cy;

        foreach (hist_counts[c, b])
            hist_counts[c][b] = '0;

        // Directed words under the reset register values.
        queue_word(OP_ADD, 0, 0, 0, 0);
        queue_word(OP_ADD, 3, -4, 9, 63);
        queue_word(OP_ADD, -63, 0, 1, 0);
        queue_word(OP_ADD, 64, 0, 1, 0);
        queue_word(OP_ADD, 8388607, 8388607, 2, 0);
        queue_word(OP_ADD, -8388608, -8388608, 3, 0);
        queue_word(OP_ADD, 3, 4, 10, 0);
        queue_word(OP_ADD, 0, 0, 15, 0);
        queue_word(OP_READ, -1, 8388607, 9, 5);
        queue_word(OP_READ, 0, 0, 1, 63);
        queue_word(OP_READ, 0, 0, 15, 63);
        queue_word(OP_NONE, -8388608, -1, 15, 63);
        queue_word(OP_CLEAR, 8388607, -8388608, 9, 5);
        queue_word(OP_READ, 0, 0, 9, 5);

        // Corner center, zero bin width and no bins in use.
        queue_config(REG_CENTER_X, -8388608);
        queue_config(REG_CENTER_Y, 8388607);
        queue_config(REG_BIN_WIDTH, 0);
        queue_config(REG_BINS_IN_USE, 0);
        queue_word(OP_ADD, 8388607, -8388608, 4, 0);
        queue_word(OP_ADD, -8388608, 8388607, 4, 0);

        // Widest bins and more bins in use than the store holds.
        queue_config(REG_BIN_WIDTH, 1048575);
        queue_config(REG_BINS_IN_USE, 127);
        queue_word(OP_ADD, 8388607, -8388608, 5, 0);
        queue_word(OP_READ, 0, 0, 5, 22);
        queue_word(OP_ADD, -8388608, 8388607, 5, 0);

        // A single bin in use.
        queue_config(REG_BIN_WIDTH, 1);
        queue_config(REG_BINS_IN_USE, 1);
        queue_word(OP_ADD, -8388607, 8388607, 6, 0);
        queue_word(OP_ADD, -8388608, 8388607, 6, 0);
        queue_word(OP_READ, 0, 0, 6, 0);
        queue_marker(ACT_DRAIN, 0);

        // Random phases, each under its own register setting; the sender pacing changes every other phase.
        for (p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                queue_marker(ACT_PACE, 18);
            else if (p == 2)
                queue_marker(ACT_PACE, 70);
            else if (p == 4)
                queue_marker(ACT_PACE, 0);
            if (p % 2 == 0)
            begin
                cx = rand24();
                cy = rand24();
            end
            else
            begin
                cx = int'($urandom_range(2000)) - 1000;
                cy = int'($urandom_range(2000)) - 1000;
            end
            case (p)
                0:
                begin
                    bw = 1;
                    biu = 64;
                end
                1:
                begin
                    bw = $urandom_range(16, 2);
                    biu = $urandom_range(64, 1);
                end
                2:
                begin
                    bw = $urandom_range(4096, 17);
                    biu = $urandom_range(127, 65);
                end
                3:
                begin
                    bw = 0;
                    biu = $urandom_range(8, 1);
                end
                4:
                begin
                    bw = $urandom_range(1048575, 4097);
                    biu = 64;
                end
                default:
                begin
                    bw = $urandom_range(200, 1);
                    biu = $urandom_range(64, 1);
                end
            endcase
            queue_config(REG_CENTER_X, cx);
            queue_config(REG_CENTER_Y, cy);
            queue_config(REG_BIN_WIDTH, bw);
            queue_config(REG_BINS_IN_USE, biu);
            repeat (PHASE_WORDS)
            begin
                queue_random_word();
                if ($urandom_range(199) == 0)
                    queue_marker(ACT_DRAIN, 0);
            end
        end

        // Reset once, then let the driver run the queue.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_done && due_results.size() == 0))
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Run covered %0d adds (%0d flagged), %0d reads, %0d clears, %0d unused opcodes",
                 words_by_op[OP_ADD], flagged_adds, words_by_op[OP_READ],
                 words_by_op[OP_CLEAR], words_by_op[OP_NONE]);
        $display("and %0d register writes; %0d result words checked, %0d mismatches.",
                 config_writes, results_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/cdh_pkg.sv
rtl/cdh_dist_unit.sv
rtl/category_distance_histogram_unit.sv
verif/tb_top.sv
